// ===== rtl/bpfa_pkg.sv =====
// Package for the bitmap page frame allocator.
// Holds request and status codes, controller states and the command/status structs.
// No dependencies.
package bpfa_pkg;

    // Used-map word geometry
    localparam int WORD_W    = 32;
    localparam int WORD_BITS = 5;
    localparam logic [WORD_W-1:0] ALL_USED = {WORD_W{1'b1}};

    // Request codes
    localparam logic [2:0] REQ_ALLOC      = 3'd0;
    localparam logic [2:0] REQ_FREE_PAGE  = 3'd1;
    localparam logic [2:0] REQ_FREE_RANGE = 3'd2;
    localparam logic [2:0] REQ_RESV_RANGE = 3'd3;
    localparam logic [2:0] REQ_RESET_ALL  = 3'd4;
    localparam logic [2:0] REQ_COMMIT     = 3'd5;
    localparam logic [2:0] REQ_QUERY      = 3'd6;

    // Result status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NO_FREE = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SETUP1,
        S_SETUP2,
        S_RD,
        S_EVAL,
        S_ACC,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        PTR_ZERO,
        PTR_HINT,
        PTR_START,
        PTR_PAGE
    } t_ptr_sel;

    // Controller to datapath
    typedef struct packed {
        logic       capture;
        logic       setup1;
        logic       setup2;
        logic       ptr_load;
        t_ptr_sel   ptr_sel;
        logic       ptr_inc;
        logic       rd;
        logic       sweep_wr;
        logic       clear_counts;
        logic       commit;
        logic       ev_alloc;
        logic       mask_hint;
        logic       ev_free;
        logic       ev_range;
        logic       acc;
        logic       out_load;
        logic [1:0] status;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [2:0] req;
        logic       range_empty;
        logic       page_in_range;
        logic       hint_top;
        logic       ptr_top;
        logic       ptr_hint_word;
        logic       ptr_end_word;
        logic       alloc_found;
        logic       page_used;
        logic       out_free;
    } t_sts;

endpackage

// ===== rtl/bpfa_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module bpfa_ram #(
    parameter int W = 32,
    parameter int D = 2048
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bpfa_ctrl.sv =====
// Controller state machine of the page frame allocator.
// Depends on bpfa_pkg; drives bpfa_dp through t_cmd and reads t_sts.
module bpfa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  bpfa_pkg::t_sts   i_sts,
    output bpfa_pkg::t_cmd   o_cmd
);

    bpfa_pkg::t_state r_state, n_state;
    logic             r_phase2, n_phase2;
    logic             r_from_req, n_from_req;
    logic [1:0]       r_stat, n_stat;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= bpfa_pkg::S_CLEAR;
            r_phase2   <= 1'b0;
            r_from_req <= 1'b0;
            r_stat     <= bpfa_pkg::ST_DONE;
        end else begin
            r_state    <= n_state;
            r_phase2   <= n_phase2;
            r_from_req <= n_from_req;
            r_stat     <= n_stat;
        end
    end

    // Next state
    always_comb begin
        n_state    = r_state;
        n_phase2   = r_phase2;
        n_from_req = r_from_req;
        n_stat     = r_stat;
        unique case (r_state)
            bpfa_pkg::S_CLEAR: begin
                if (i_sts.ptr_top) begin
                    n_state = r_from_req ? bpfa_pkg::S_DONE : bpfa_pkg::S_IDLE;
                end
            end
            bpfa_pkg::S_IDLE: begin
                n_from_req = 1'b0;
                if (i_s_tvalid) begin
                    n_state = bpfa_pkg::S_SETUP1;
                end
            end
            bpfa_pkg::S_SETUP1: begin
                n_state = bpfa_pkg::S_SETUP2;
            end
            bpfa_pkg::S_SETUP2: begin
                n_stat = bpfa_pkg::ST_DONE;
                case (i_sts.req)
                    bpfa_pkg::REQ_ALLOC: begin
                        n_phase2 = i_sts.hint_top;
                        n_state  = bpfa_pkg::S_RD;
                    end
                    bpfa_pkg::REQ_FREE_PAGE: begin
                        if (i_sts.page_in_range) begin
                            n_state = bpfa_pkg::S_RD;
                        end else begin
                            n_stat  = bpfa_pkg::ST_IGNORED;
                            n_state = bpfa_pkg::S_DONE;
                        end
                    end
                    bpfa_pkg::REQ_FREE_RANGE, bpfa_pkg::REQ_RESV_RANGE: begin
                        n_state = i_sts.range_empty ? bpfa_pkg::S_DONE : bpfa_pkg::S_RD;
                    end
                    bpfa_pkg::REQ_RESET_ALL: begin
                        n_from_req = 1'b1;
                        n_state    = bpfa_pkg::S_CLEAR;
                    end
                    default: begin
                        n_state = bpfa_pkg::S_DONE;
                    end
                endcase
            end
            bpfa_pkg::S_RD: begin
                n_state = bpfa_pkg::S_EVAL;
            end
            bpfa_pkg::S_EVAL: begin
                case (i_sts.req)
                    bpfa_pkg::REQ_ALLOC: begin
                        if (i_sts.alloc_found) begin
                            n_state = bpfa_pkg::S_DONE;
                        end else if (!r_phase2) begin
                            if (i_sts.ptr_top) begin
                                n_phase2 = 1'b1;
                            end
                            n_state = bpfa_pkg::S_RD;
                        end else if (i_sts.ptr_hint_word || i_sts.ptr_top) begin
                            n_stat  = bpfa_pkg::ST_NO_FREE;
                            n_state = bpfa_pkg::S_DONE;
                        end else begin
                            n_state = bpfa_pkg::S_RD;
                        end
                    end
                    bpfa_pkg::REQ_FREE_PAGE: begin
                        n_stat  = i_sts.page_used ? bpfa_pkg::ST_DONE : bpfa_pkg::ST_IGNORED;
                        n_state = bpfa_pkg::S_DONE;
                    end
                    default: begin
                        n_state = bpfa_pkg::S_ACC;
                    end
                endcase
            end
            bpfa_pkg::S_ACC: begin
                n_state = i_sts.ptr_end_word ? bpfa_pkg::S_DONE : bpfa_pkg::S_RD;
            end
            bpfa_pkg::S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = bpfa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bpfa_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            bpfa_pkg::S_CLEAR: begin
                o_cmd.sweep_wr = 1'b1;
            end
            bpfa_pkg::S_IDLE: begin
                o_s_tready  = 1'b1;
                o_cmd.capture = i_s_tvalid;
            end
            bpfa_pkg::S_SETUP1: begin
                o_cmd.setup1 = 1'b1;
            end
            bpfa_pkg::S_SETUP2: begin
                o_cmd.setup2 = 1'b1;
                case (i_sts.req)
                    bpfa_pkg::REQ_ALLOC: begin
                        o_cmd.ptr_load = 1'b1;
                        o_cmd.ptr_sel  = i_sts.hint_top ? bpfa_pkg::PTR_ZERO
                                                        : bpfa_pkg::PTR_HINT;
                    end
                    bpfa_pkg::REQ_FREE_PAGE: begin
                        o_cmd.ptr_load = 1'b1;
                        o_cmd.ptr_sel  = bpfa_pkg::PTR_PAGE;
                    end
                    bpfa_pkg::REQ_FREE_RANGE, bpfa_pkg::REQ_RESV_RANGE: begin
                        o_cmd.ptr_load = 1'b1;
                        o_cmd.ptr_sel  = bpfa_pkg::PTR_START;
                    end
                    bpfa_pkg::REQ_RESET_ALL: begin
                        o_cmd.ptr_load     = 1'b1;
                        o_cmd.ptr_sel      = bpfa_pkg::PTR_ZERO;
                        o_cmd.clear_counts = 1'b1;
                    end
                    bpfa_pkg::REQ_COMMIT: begin
                        o_cmd.commit = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            bpfa_pkg::S_RD: begin
                o_cmd.rd = 1'b1;
            end
            bpfa_pkg::S_EVAL: begin
                case (i_sts.req)
                    bpfa_pkg::REQ_ALLOC: begin
                        o_cmd.ev_alloc  = 1'b1;
                        o_cmd.mask_hint = !r_phase2;
                        if (!i_sts.alloc_found) begin
                            if (!r_phase2 && i_sts.ptr_top) begin
                                o_cmd.ptr_load = 1'b1;
                                o_cmd.ptr_sel  = bpfa_pkg::PTR_ZERO;
                            end else if (!r_phase2
                                         || !(i_sts.ptr_hint_word || i_sts.ptr_top)) begin
                                o_cmd.ptr_inc = 1'b1;
                            end
                        end
                    end
                    bpfa_pkg::REQ_FREE_PAGE: begin
                        o_cmd.ev_free = 1'b1;
                    end
                    default: begin
                        o_cmd.ev_range = 1'b1;
                    end
                endcase
            end
            bpfa_pkg::S_ACC: begin
                o_cmd.acc     = 1'b1;
                o_cmd.ptr_inc = !i_sts.ptr_end_word;
            end
            bpfa_pkg::S_DONE: begin
                o_cmd.out_load = i_sts.out_free;
                o_cmd.status   = r_stat;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== rtl/bpfa_dp.sv =====
// Datapath of the page frame allocator: used-map RAM, counters, hint, region math.
// Depends on bpfa_pkg and bpfa_ram; controlled by bpfa_ctrl.
module bpfa_dp #(
    parameter int NUM_PAGES  = 65536,
    parameter int PAGE_BYTES = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bpfa_pkg::t_cmd   i_cmd,
    output bpfa_pkg::t_sts   o_sts,
    input  logic [2:0]       i_req,
    input  logic [63:0]      i_addr,
    input  logic [63:0]      i_length,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [1:0]       o_status,
    output logic [27:0]      o_page_addr,
    output logic [16:0]      o_free_count,
    output logic [16:0]      o_total_count
);

    localparam int WW  = bpfa_pkg::WORD_W;
    localparam int WB  = bpfa_pkg::WORD_BITS;
    localparam int NW  = (NUM_PAGES + WW - 1) / WW;
    localparam int AW  = $clog2(NW);
    localparam int CW  = $clog2(NUM_PAGES + 1);
    localparam int PBW = $clog2(PAGE_BYTES);
    localparam logic [CW-1:0] NPG   = CW'(NUM_PAGES);
    localparam logic [63:0]   NPG64 = 64'(NUM_PAGES);
    localparam logic [AW-1:0] TOP_W = AW'(NW - 1);

    // Captured request
    logic [2:0]    r_req;
    logic [63:0]   r_addr;
    logic [63:0]   r_len;
    logic [64:0]   r_sum;
    logic [63:0]   r_sraw;
    logic [CW-1:0] r_s, r_e, r_pidx;
    logic [AW-1:0] r_ptr;
    logic [CW-1:0] r_hint, r_free, r_total;
    logic [27:0]   r_paddr;
    logic [5:0]    r_chg;
    logic          r_ovalid;
    logic [1:0]    r_ostatus;
    logic [27:0]   r_opaddr;
    logic [16:0]   r_ofree, r_ototal;

    logic [WW-1:0] rd_data;
    logic          we;
    logic [WW-1:0] wdata;

    // Region bounds, clamped to the page count
    logic [63:0]   end_raw, page_raw;
    logic [CW-1:0] s_c, e_c, pidx_c, em1;
    always_comb begin
        end_raw  = r_sum[63:0] >> PBW;
        page_raw = r_addr >> PBW;
        s_c      = (r_sraw >= NPG64) ? NPG : CW'(r_sraw);
        if (r_sum[64] || end_raw >= NPG64) begin
            e_c = NPG;
        end else begin
            e_c = CW'(end_raw);
        end
        pidx_c = CW'(page_raw);
        em1    = r_e - CW'(1);
    end

    // Word pointer compares
    logic ptr_hint_word, ptr_end_word, ptr_start_word;
    assign ptr_hint_word  = ({1'b0, r_ptr} == (AW+1)'(r_hint >> WB));
    assign ptr_end_word   = (r_ptr == AW'(em1 >> WB));
    assign ptr_start_word = (r_ptr == AW'(r_s >> WB));

    // Alloc: lowest free bit in the word, bits below the hint masked in the first word
    logic [WW-1:0] hmask, free_vec;
    logic [WB-1:0] pos;
    logic          found;
    logic [63:0]   idx64;
    always_comb begin
        hmask = '0;
        if (i_cmd.mask_hint && ptr_hint_word) begin
            hmask = (WW'(1) << r_hint[WB-1:0]) - WW'(1);
        end
        free_vec = ~(rd_data | hmask);
        found    = |free_vec;
        pos      = '0;
        for (int k = WW - 1; k >= 0; k--) begin
            if (free_vec[k]) begin
                pos = WB'(k);
            end
        end
        idx64 = 64'({r_ptr, pos});
    end

    // Range: page mask within the current word
    logic [WB-1:0] lo, hi;
    logic [WW-1:0] rmask, changed;
    logic          is_free_range;
    always_comb begin
        lo    = ptr_start_word ? r_s[WB-1:0] : '0;
        hi    = ptr_end_word ? em1[WB-1:0] : WB'(WW - 1);
        rmask = (bpfa_pkg::ALL_USED << lo) & (bpfa_pkg::ALL_USED >> (WB'(WW - 1) - hi));
        is_free_range = (r_req == bpfa_pkg::REQ_FREE_RANGE);
        changed = is_free_range ? (rd_data & rmask) : (~rd_data & rmask);
    end

    logic page_used;
    assign page_used = rd_data[r_pidx[WB-1:0]];

    // RAM write select
    always_comb begin
        we    = 1'b0;
        wdata = bpfa_pkg::ALL_USED;
        if (i_cmd.sweep_wr) begin
            we = 1'b1;
        end else if (i_cmd.ev_alloc && found) begin
            we    = 1'b1;
            wdata = rd_data | (WW'(1) << pos);
        end else if (i_cmd.ev_free && page_used) begin
            we    = 1'b1;
            wdata = rd_data & ~(WW'(1) << r_pidx[WB-1:0]);
        end else if (i_cmd.ev_range) begin
            we    = 1'b1;
            wdata = is_free_range ? (rd_data & ~rmask) : (rd_data | rmask);
        end
    end

    bpfa_ram #(
        .W (WW),
        .D (NW)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_ptr),
        .i_wdata (wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (r_ptr),
        .o_rdata (rd_data)
    );

    // Request payload and region setup
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req   <= i_req;
            r_addr  <= i_addr;
            r_len   <= i_length;
        end
        if (i_cmd.setup1) begin
            r_sum  <= {1'b0, r_addr} + {1'b0, r_len};
            r_sraw <= (r_addr >> PBW) + 64'(|r_addr[PBW-1:0]);
        end
        if (i_cmd.setup2) begin
            r_s    <= s_c;
            r_e    <= e_c;
            r_pidx <= pidx_c;
        end
        if (i_cmd.capture) begin
            r_paddr <= '0;
        end else if (i_cmd.ev_alloc && found) begin
            r_paddr <= 28'(idx64 << PBW);
        end
        if (i_cmd.ev_range) begin
            r_chg <= 6'($countones(changed));
        end
    end

    // Pointer, hint and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr   <= '0;
            r_hint  <= '0;
            r_free  <= '0;
            r_total <= '0;
        end else begin
            if (i_cmd.ptr_load) begin
                case (i_cmd.ptr_sel)
                    bpfa_pkg::PTR_HINT:  r_ptr <= AW'(r_hint >> WB);
                    bpfa_pkg::PTR_START: r_ptr <= AW'(s_c >> WB);
                    bpfa_pkg::PTR_PAGE:  r_ptr <= AW'(pidx_c >> WB);
                    default:             r_ptr <= '0;
                endcase
            end else if (i_cmd.ptr_inc || (i_cmd.sweep_wr && r_ptr != TOP_W)) begin
                r_ptr <= r_ptr + AW'(1);
            end
            if (i_cmd.clear_counts) begin
                r_free <= '0;
                r_hint <= '0;
            end else if (i_cmd.ev_alloc && found) begin
                r_free <= r_free - CW'(1);
                r_hint <= CW'(idx64) + CW'(1);
            end else if (i_cmd.ev_free && page_used) begin
                r_free <= r_free + CW'(1);
                if (r_pidx < r_hint) begin
                    r_hint <= r_pidx;
                end
            end else if (i_cmd.acc) begin
                r_free <= is_free_range ? (r_free + CW'(r_chg)) : (r_free - CW'(r_chg));
            end
            if (i_cmd.commit) begin
                r_total <= r_free;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_ostatus <= i_cmd.status;
            r_opaddr  <= (i_cmd.status == bpfa_pkg::ST_DONE) ? r_paddr : '0;
            r_ofree   <= 17'(r_free);
            r_ototal  <= 17'(r_total);
        end
    end

    assign o_valid       = r_ovalid;
    assign o_status      = r_ostatus;
    assign o_page_addr   = r_opaddr;
    assign o_free_count  = r_ofree;
    assign o_total_count = r_ototal;

    // Status to controller
    always_comb begin
        o_sts               = '0;
        o_sts.req           = r_req;
        o_sts.range_empty   = (s_c >= e_c);
        o_sts.page_in_range = (page_raw < NPG64);
        o_sts.hint_top      = (r_hint >= NPG);
        o_sts.ptr_top       = (r_ptr == TOP_W);
        o_sts.ptr_hint_word = ptr_hint_word;
        o_sts.ptr_end_word  = ptr_end_word;
        o_sts.alloc_found   = found;
        o_sts.page_used     = page_used;
        o_sts.out_free      = !r_ovalid || i_ready;
    end

    // Checks
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= NPG)
        else $error("free count above page count");
    a_hint_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hint <= NPG)
        else $error("search hint above page count");
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> r_ovalid)
        else $error("result word lost on load");
    a_fail_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ostatus != bpfa_pkg::ST_DONE) |-> (r_opaddr == '0))
        else $error("page address on failed request");

endmodule

// ===== rtl/bitmap_page_frame_allocator.sv =====
// Bitmap page frame allocator: one used bit per physical page, kept in a RAM of
// 32-bit words, with next-fit allocation, page free, range free/reserve, reset-all,
// commit and query. Items are handled one at a time. After reset, and for every
// reset-all request, a clearing pass writes the whole map, during which no word is
// accepted. Query and commit read no map word, an in-range page free reads one,
// an alloc searches from the hint word to the top word and then from word 0 to the
// hint word, and a range reads and updates every map word it covers. Each map word
// is read through the RAM's registered read port. A finished result sits in an
// output register, so the next word can be accepted while it waits.
// Depends on bpfa_pkg, bpfa_ctrl, bpfa_dp.
module bitmap_page_frame_allocator #(
    parameter int NUM_PAGES  = 65536,
    parameter int PAGE_BYTES = 4096
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [127:0] i_s_tdata,  // addr [63:0], length [127:64]
    input  logic [2:0]   i_s_tuser,  // req_type [2:0]
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [63:0]  o_m_tdata,  // page_addr [27:0], free_count [44:28],
                                     // total_count [61:45], zero [63:62]
    output logic [1:0]   o_m_tuser   // status [1:0]
);

    bpfa_pkg::t_cmd cmd;
    bpfa_pkg::t_sts sts;
    logic [27:0]    page_addr;
    logic [16:0]    free_count, total_count;

    bpfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bpfa_dp #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_req         (i_s_tuser),
        .i_addr        (i_s_tdata[63:0]),
        .i_length      (i_s_tdata[127:64]),
        .o_valid       (o_m_tvalid),
        .i_ready       (i_m_tready),
        .o_status      (o_m_tuser),
        .o_page_addr   (page_addr),
        .o_free_count  (free_count),
        .o_total_count (total_count)
    );

    assign o_m_tdata = {2'b00, total_count, free_count, page_addr};

endmodule
